// File: hw/rtl/vlan_tag_demux_mux_unit_assert.svh
// ----------------------------------------------------------------------------
// vlan tag demux/mux assertion macros
// concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef VLAN_TAG_DEMUX_MUX_UNIT_ASSERT_SVH
`define VLAN_TAG_DEMUX_MUX_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define VTDM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vtdm assertion failed");
// next-cycle implication
`define VTDM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vtdm assertion failed");
`else
`define VTDM_ASSERT_IMP(label, ante, cons)
`define VTDM_ASSERT_NXT(label, ante, cons)
`endif

`endif

// File: hw/rtl/vtdm_pkg.sv
// ----------------------------------------------------------------------------
// vtdm_pkg
// shared codes, widths and types of the vlan tag demux/mux unit
// ----------------------------------------------------------------------------
package vtdm_pkg;

    localparam int FUNC_W   = 3;
    localparam int PORT_W   = 4;
    localparam int WORD_W   = 16;
    localparam int VID_W    = 12;
    localparam int DEST_W   = 2;
    localparam int EDIT_W   = 2;
    localparam int STAT_W   = 3;

    localparam int IN_DATA_W  = 56;
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 24;

    localparam logic [WORD_W-1:0] TPID_8021Q   = 16'h8100;
    localparam logic [WORD_W-1:0] VID_MASK     = 16'h0FFF;

    localparam logic [FUNC_W-1:0] FUNC_TRUNK   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_NOMATCH = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_FILTER  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_ADD     = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DELETE  = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd5;

    localparam logic [DEST_W-1:0] DEST_TRUNK   = 2'd0;
    localparam logic [DEST_W-1:0] DEST_NOMATCH = 2'd1;
    localparam logic [DEST_W-1:0] DEST_FILTER  = 2'd2;
    localparam logic [DEST_W-1:0] DEST_NONE    = 2'd3;

    localparam logic [EDIT_W-1:0] EDIT_NONE    = 2'd0;
    localparam logic [EDIT_W-1:0] EDIT_STRIP   = 2'd1;
    localparam logic [EDIT_W-1:0] EDIT_INSERT  = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK          = 3'd0;
    localparam logic [STAT_W-1:0] STAT_INVALID     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_EXISTS      = 3'd3;
    localparam logic [STAT_W-1:0] STAT_UNSUPPORTED = 3'd4;

    typedef struct packed {
        logic load_item;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic [DEST_W-1:0] dest;
        logic [PORT_W-1:0] dest_port;
        logic [EDIT_W-1:0] edit;
        logic [VID_W-1:0]  tag_out;
        logic [STAT_W-1:0] status;
    } result_t;

endpackage

// File: hw/rtl/vlan_tag_demux_mux_unit.sv
// ----------------------------------------------------------------------------
// vlan_tag_demux_mux_unit
// 802.1q tag strip/insert decision with a per-port vlan filter table
// ----------------------------------------------------------------------------
// Each item is first registered, then its vlan id is compared in parallel
// against all filter entries for the decision and the table update. The
// result sits in an output register, so the next item is taken while a
// result still waits on m_axis_tready; a full output register stalls the
// decision step. One result per item, in order.
// ----------------------------------------------------------------------------
`include "vlan_tag_demux_mux_unit_assert.svh"

module vlan_tag_demux_mux_unit
    import vtdm_pkg::*;
#(
    parameter int FILTER_PORTS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // port[3:0], vlan_request[19:4], outer_type[35:20], tag_control[51:36], zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // func[2:0], short_header[3]
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // dest[1:0], dest_port[5:2], edit[7:6], tag_out[19:8], status[22:20], zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    cmd_t    cmd;
    result_t result;

    vtdm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    vtdm_dpath #(
        .FILTER_PORTS (FILTER_PORTS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .func         (s_axis_tuser[2:0]),
        .port         (s_axis_tdata[3:0]),
        .vlan_request (s_axis_tdata[19:4]),
        .outer_type   (s_axis_tdata[35:20]),
        .tag_control  (s_axis_tdata[51:36]),
        .short_header (s_axis_tuser[3]),
        .result       (result)
    );

    assign m_axis_tdata = {1'b0, result.status, result.tag_out, result.edit,
                           result.dest_port, result.dest};

    // one item in flight: busy right after a transaction is taken
    `VTDM_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // with the output register empty the item passes the exec state unstalled, then its result shows
    `VTDM_ASSERT_IMP(a_result_latency, s_axis_tvalid && s_axis_tready && !m_axis_tvalid, ##2 m_axis_tvalid)
    // a stripped tag always goes to a filter port with status ok
    `VTDM_ASSERT_IMP(a_strip_to_filter, m_axis_tvalid && (m_axis_tdata[7:6] == EDIT_STRIP), (m_axis_tdata[1:0] == DEST_FILTER) && (m_axis_tdata[22:20] == STAT_OK))

endmodule

// File: hw/rtl/vtdm_ctrl.sv
// ----------------------------------------------------------------------------
// vtdm_ctrl
// controller: input acceptance, decision commit and output valid tracking
// ----------------------------------------------------------------------------
module vtdm_ctrl
    import vtdm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // hold the decision until the output register can take it
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hw/rtl/vtdm_dpath.sv
// ----------------------------------------------------------------------------
// vtdm_dpath
// datapath: item register, filter table, parallel vlan compare, result register
// ----------------------------------------------------------------------------
module vtdm_dpath
    import vtdm_pkg::*;
#(
    parameter int FILTER_PORTS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    input  logic [FUNC_W-1:0] func,
    input  logic [PORT_W-1:0] port,
    input  logic [WORD_W-1:0] vlan_request,
    input  logic [WORD_W-1:0] outer_type,
    input  logic [WORD_W-1:0] tag_control,
    input  logic              short_header,
    output result_t           result
);

    // only ports reachable through the port field need storage
    localparam int STORE_N = (FILTER_PORTS < (1 << PORT_W)) ? FILTER_PORTS : (1 << PORT_W);
    localparam int IDX_W   = (STORE_N > 1) ? $clog2(STORE_N) : 1;

    logic [FUNC_W-1:0] func_reg;
    logic [PORT_W-1:0] port_reg;
    logic [WORD_W-1:0] vreq_reg;
    logic [WORD_W-1:0] etype_reg;
    logic [WORD_W-1:0] tci_reg;
    logic              short_reg;

    logic [STORE_N-1:0] active_reg;
    logic [VID_W-1:0]   vid_reg [STORE_N];

    result_t result_reg;
    result_t result_next;

    logic [VID_W-1:0]   key;
    logic [STORE_N-1:0] match;
    logic               hit_found;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   port_idx;
    logic               port_ok;
    logic               bound;
    logic [VID_W-1:0]   port_vid;
    logic               do_add;
    logic               do_delete;

    assign port_ok  = (int'(port_reg) < FILTER_PORTS);
    assign port_idx = port_reg[IDX_W-1:0];
    assign bound    = port_ok && active_reg[port_idx];
    assign port_vid = vid_reg[port_idx];

    // add looks up the requested id, trunk frames the tag's id
    assign key = (func_reg == FUNC_ADD) ? vreq_reg[VID_W-1:0] : tci_reg[VID_W-1:0];

    always_comb
    begin
        for (int i = 0; i < STORE_N; i++)
        begin
            match[i] = active_reg[i] && (vid_reg[i] == key);
        end
    end

    // lowest matching port wins
    always_comb
    begin
        hit_found = 1'b0;
        hit_idx   = '0;
        for (int i = STORE_N - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_found = 1'b1;
                hit_idx   = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        result_next           = '0;
        result_next.dest      = DEST_NONE;
        result_next.dest_port = '0;
        result_next.edit      = EDIT_NONE;
        result_next.tag_out   = '0;
        result_next.status    = STAT_OK;
        do_add                = 1'b0;
        do_delete             = 1'b0;
        if ((func_reg inside {FUNC_TRUNK, FUNC_NOMATCH, FUNC_FILTER}) && short_reg)
        begin
            result_next.status = STAT_INVALID;
        end
        else
        begin
            case (func_reg)
                FUNC_TRUNK:
                begin
                    if ((etype_reg == TPID_8021Q) && hit_found)
                    begin
                        result_next.dest      = DEST_FILTER;
                        result_next.dest_port = PORT_W'(hit_idx);
                        result_next.edit      = EDIT_STRIP;
                    end
                    else
                    begin
                        result_next.dest = DEST_NOMATCH;
                    end
                end
                FUNC_NOMATCH:
                begin
                    result_next.dest = DEST_TRUNK;
                end
                FUNC_FILTER:
                begin
                    if (bound)
                    begin
                        result_next.dest    = DEST_TRUNK;
                        result_next.edit    = EDIT_INSERT;
                        result_next.tag_out = port_vid;
                    end
                    else
                    begin
                        result_next.status = STAT_UNSUPPORTED;
                    end
                end
                FUNC_ADD:
                begin
                    if ((vreq_reg & ~VID_MASK) != '0)
                    begin
                        result_next.status = STAT_INVALID;
                    end
                    else if (!port_ok)
                    begin
                        result_next.status = STAT_NOT_FOUND;
                    end
                    else if (bound || hit_found)
                    begin
                        result_next.status = STAT_EXISTS;
                    end
                    else
                    begin
                        do_add = 1'b1;
                    end
                end
                FUNC_DELETE:
                begin
                    if (bound)
                    begin
                        do_delete = 1'b1;
                    end
                    else
                    begin
                        result_next.status = STAT_NOT_FOUND;
                    end
                end
                FUNC_READ:
                begin
                    if (bound)
                    begin
                        result_next.tag_out = port_vid;
                    end
                    else
                    begin
                        result_next.status = STAT_NOT_FOUND;
                    end
                end
                default:
                begin
                    result_next.status = STAT_INVALID;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            func_reg  <= func;
            port_reg  <= port;
            vreq_reg  <= vlan_request;
            etype_reg <= outer_type;
            tci_reg   <= tag_control;
            short_reg <= short_header;
        end
        if (cmd.commit)
        begin
            result_reg <= result_next;
        end
        if (cmd.commit && do_add)
        begin
            vid_reg[port_idx] <= vreq_reg[VID_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else if (cmd.commit && (do_add || do_delete))
        begin
            active_reg[port_idx] <= do_add;
        end
    end

    assign result = result_reg;

endmodule
